FILE: rtl/core/eotq_pkg.sv
// shared types, codes and widths for the expiry ordered timer queue
package eotq_pkg;

    localparam int SLOTS_DEF = 64;

    localparam int MODE_W  = 2;
    localparam int KIND_W  = 2;
    localparam int ID_W    = 32;
    localparam int OWNER_W = 32;
    localparam int DELAY_W = 32;
    localparam int TIME_W  = 48;

    localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_CREATED  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd2;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [ID_W-1:0]   ID_FIRST = 32'd1;

    typedef struct packed {
        logic [TIME_W-1:0]  expiry;
        logic [ID_W-1:0]    ident;
        logic [OWNER_W-1:0] owner;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CREATE,
        ST_CAN_SCAN,
        ST_CAN_DRAIN,
        ST_TICK,
        ST_PASS_SCAN,
        ST_PASS_DRAIN,
        ST_PASS_END
    } state_t;

    typedef struct packed {
        logic load_item;
        logic scan_start;
        logic scan_issue;
        logic tick_advance;
        logic do_create;
        logic pass_commit;
        logic pass_finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] req_mode;
        logic              out_free;
        logic              scan_last;
        logic              best_found;
        logic              hold_valid;
    } dp_status_t;

endpackage

FILE: rtl/core/eotq_req_if.sv
// request channel: one create, cancel or tick word
interface eotq_req_if import eotq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [DELAY_W-1:0] delay;
    logic [OWNER_W-1:0] src_tag;
    logic [ID_W-1:0]    cancel_id;

    modport source (output valid, output mode, output delay, output src_tag,
                    output cancel_id, input ready);
    modport sink (input valid, input mode, input delay, input src_tag,
                  input cancel_id, output ready);
endinterface

FILE: rtl/core/eotq_rsp_if.sv
// response channel: created, fired or rejected word
interface eotq_rsp_if import eotq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    ident;
    logic [OWNER_W-1:0] owner;
    logic [TIME_W-1:0]  expiry;
    logic               last;

    modport source (output valid, output kind, output ident, output owner,
                    output expiry, output last, input ready);
    modport sink (input valid, input kind, input ident, input owner,
                  input expiry, input last, output ready);
endinterface

FILE: rtl/core/eotq_ram.sv
// generic single write port, single read port ram with registered read
module eotq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/eotq_ctrl.sv
// sequencer for create, cancel sweep and tick firing passes
module eotq_ctrl import eotq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t st,
    output ctl_cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (st.req_mode)
                        MODE_CREATE: state_next = ST_CREATE;
                        MODE_CANCEL: state_next = ST_CAN_SCAN;
                        MODE_TICK:   state_next = ST_TICK;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CREATE:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CAN_SCAN:
            begin
                if (st.scan_last)
                begin
                    state_next = ST_CAN_DRAIN;
                end
            end
            ST_CAN_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            ST_TICK:
            begin
                state_next = ST_PASS_SCAN;
            end
            ST_PASS_SCAN:
            begin
                if (st.scan_last)
                begin
                    state_next = ST_PASS_DRAIN;
                end
            end
            ST_PASS_DRAIN:
            begin
                state_next = ST_PASS_END;
            end
            ST_PASS_END:
            begin
                if (st.best_found)
                begin
                    if (!st.hold_valid || st.out_free)
                    begin
                        state_next = ST_PASS_SCAN;
                    end
                end
                else if (!st.hold_valid || st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready      = 1'b1;
                cmd.load_item  = accept;
                cmd.scan_start = accept;
            end
            ST_CREATE:
            begin
                cmd.do_create = st.out_free;
            end
            ST_CAN_SCAN, ST_PASS_SCAN:
            begin
                cmd.scan_issue = 1'b1;
            end
            ST_TICK:
            begin
                cmd.tick_advance = 1'b1;
                cmd.scan_start   = 1'b1;
            end
            ST_PASS_END:
            begin
                if (st.best_found)
                begin
                    cmd.pass_commit = !st.hold_valid || st.out_free;
                    cmd.scan_start  = !st.hold_valid || st.out_free;
                end
                else
                begin
                    cmd.pass_finish = st.hold_valid && st.out_free;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // a held result must never be overwritten while the output register is busy
    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pass_commit |-> (!st.hold_valid || st.out_free))
        else $error("commit while held result cannot move out");

    a_create_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_create |-> st.out_free)
        else $error("create while output register busy");

    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item |=> state_reg != ST_PASS_END && state_reg != ST_PASS_DRAIN)
        else $error("accepted word jumped into a firing pass");

endmodule

FILE: rtl/core/eotq_dpath.sv
// entry store, valid bits, time and id counters, scan compare and output register
module eotq_dpath import eotq_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [MODE_W-1:0]  req_mode,
    input  logic [DELAY_W-1:0] req_delay,
    input  logic [OWNER_W-1:0] req_source,
    input  logic [ID_W-1:0]    req_cancel_id,
    input  ctl_cmd_t           cmd,
    output dp_status_t         st,
    eotq_rsp_if.source         rsp
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // control state
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [TIME_W-1:0] clock_now_reg, clock_now_next;
    logic [ID_W-1:0]   next_ident_reg, next_ident_next;
    logic [IDX_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic              cmp_vld_reg;
    logic              best_found_reg, best_found_next;
    logic              hold_valid_reg, hold_valid_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [MODE_W-1:0]  mode_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [OWNER_W-1:0] source_reg;
    logic [ID_W-1:0]    cancel_id_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    entry_t             best_reg, best_next;
    logic [IDX_W-1:0]   best_slot_reg, best_slot_next;
    entry_t             hold_reg, hold_next;
    logic [KIND_W-1:0]  out_kind_reg, out_kind_next;
    logic [ID_W-1:0]    out_id_reg, out_id_next;
    logic [OWNER_W-1:0] out_owner_reg, out_owner_next;
    logic [TIME_W-1:0]  out_exp_reg, out_exp_next;
    logic               out_last_reg, out_last_next;

    logic              full;
    logic [IDX_W-1:0]  free_slot;
    logic [TIME_W:0]   exp_sum;
    logic [TIME_W-1:0] new_exp;
    logic              create_we;
    logic              out_free;
    logic              cmp_valid;
    logic              cancel_hit;
    logic              expired;
    logic              better;
    entry_t            wr_entry;
    entry_t            rd_entry;

    eotq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (SLOTS),
        .AW    (IDX_W)
    ) u_entries (
        .clk   (clk),
        .we    (create_we),
        .waddr (free_slot),
        .wdata (wr_entry),
        .raddr (scan_cnt_reg),
        .rdata (rd_entry)
    );

    // lowest free slot
    always_comb
    begin
        free_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot = IDX_W'(i);
            end
        end
    end

    assign full      = &valid_reg;
    assign exp_sum   = {1'b0, clock_now_reg} + (TIME_W + 1)'(delay_reg);
    assign new_exp   = exp_sum[TIME_W] ? TIME_MAX : exp_sum[TIME_W-1:0];
    assign create_we = cmd.do_create && !full;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign wr_entry.expiry = new_exp;
    assign wr_entry.ident  = next_ident_reg;
    assign wr_entry.owner  = source_reg;

    assign cmp_valid  = cmp_vld_reg && valid_reg[cmp_idx_reg];
    assign cancel_hit = cmp_valid && (mode_reg == MODE_CANCEL)
                        && (rd_entry.ident == cancel_id_reg);
    assign expired    = cmp_valid && (mode_reg == MODE_TICK)
                        && (rd_entry.expiry <= clock_now_reg);
    // strict compare keeps the lower slot on a full tie
    assign better = !best_found_reg
                    || (rd_entry.expiry < best_reg.expiry)
                    || ((rd_entry.expiry == best_reg.expiry)
                        && (rd_entry.ident < best_reg.ident));

    always_comb
    begin
        valid_next      = valid_reg;
        clock_now_next  = clock_now_reg;
        next_ident_next = next_ident_reg;
        scan_cnt_next   = scan_cnt_reg;
        best_found_next = best_found_reg;
        best_next       = best_reg;
        best_slot_next  = best_slot_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        out_owner_next  = out_owner_reg;
        out_exp_next    = out_exp_reg;
        out_last_next   = out_last_reg;

        if (cmd.scan_issue)
        begin
            scan_cnt_next = scan_cnt_reg + 1'b1;
        end

        if (cancel_hit)
        begin
            valid_next[cmp_idx_reg] = 1'b0;
        end

        if (expired && better)
        begin
            best_found_next = 1'b1;
            best_next       = rd_entry;
            best_slot_next  = cmp_idx_reg;
        end

        if (cmd.tick_advance)
        begin
            hold_valid_next = 1'b0;
            if (clock_now_reg != TIME_MAX)
            begin
                clock_now_next = clock_now_reg + 1'b1;
            end
        end

        if (cmd.do_create)
        begin
            out_valid_next = 1'b1;
            out_owner_next = '0;
            out_last_next  = 1'b1;
            if (full)
            begin
                out_kind_next = KIND_REJECTED;
                out_id_next   = '0;
                out_exp_next  = '0;
            end
            else
            begin
                out_kind_next         = KIND_CREATED;
                out_id_next           = next_ident_reg;
                out_exp_next          = new_exp;
                valid_next[free_slot] = 1'b1;
                next_ident_next       = next_ident_reg + 1'b1;
            end
        end

        // the previous winner goes out once another one is known to follow
        if (cmd.pass_commit)
        begin
            valid_next[best_slot_reg] = 1'b0;
            hold_valid_next           = 1'b1;
            hold_next                 = best_reg;
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = KIND_FIRED;
                out_id_next    = hold_reg.ident;
                out_owner_next = hold_reg.owner;
                out_exp_next   = hold_reg.expiry;
                out_last_next  = 1'b0;
            end
        end

        if (cmd.pass_finish)
        begin
            hold_valid_next = 1'b0;
            out_valid_next  = 1'b1;
            out_kind_next   = KIND_FIRED;
            out_id_next     = hold_reg.ident;
            out_owner_next  = hold_reg.owner;
            out_exp_next    = hold_reg.expiry;
            out_last_next   = 1'b1;
        end

        if (cmd.scan_start)
        begin
            scan_cnt_next   = '0;
            best_found_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            clock_now_reg  <= '0;
            next_ident_reg <= ID_FIRST;
            scan_cnt_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            clock_now_reg  <= clock_now_next;
            next_ident_reg <= next_ident_next;
            scan_cnt_reg   <= scan_cnt_next;
            cmp_vld_reg    <= cmd.scan_issue;
            best_found_reg <= best_found_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg      <= req_mode;
            delay_reg     <= req_delay;
            source_reg    <= req_source;
            cancel_id_reg <= req_cancel_id;
        end
        cmp_idx_reg   <= scan_cnt_reg;
        best_reg      <= best_next;
        best_slot_reg <= best_slot_next;
        hold_reg      <= hold_next;
        out_kind_reg  <= out_kind_next;
        out_id_reg    <= out_id_next;
        out_owner_reg <= out_owner_next;
        out_exp_reg   <= out_exp_next;
        out_last_reg  <= out_last_next;
    end

    assign st.req_mode   = req_mode;
    assign st.out_free   = out_free;
    assign st.scan_last  = (scan_cnt_reg == IDX_W'(SLOTS - 1));
    assign st.best_found = best_found_reg;
    assign st.hold_valid = hold_valid_reg;

    assign rsp.valid  = out_valid_reg;
    assign rsp.kind   = out_kind_reg;
    assign rsp.ident  = out_id_reg;
    assign rsp.owner  = out_owner_reg;
    assign rsp.expiry = out_exp_reg;
    assign rsp.last   = out_last_reg;

    a_commit_frees: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pass_commit |=> !valid_reg[$past(best_slot_reg)])
        else $error("fired slot still live after commit");

    a_fired_due: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_FIRED) |-> out_exp_reg <= clock_now_reg)
        else $error("timer fired before its expiry");

    a_create_fills: assert property (@(posedge clk) disable iff (!rst_n)
        create_we |=> $countones(valid_reg) == $countones($past(valid_reg)) + 1)
        else $error("create did not take exactly one slot");

endmodule

FILE: rtl/core/expiry_ordered_timer_queue.sv
// One-shot timer table of SLOTS entries, reporting expired timers in expiry order,
// lower id first on a tie. A request word is taken only while the block is idle.
// A create answers with the new id or a rejection when full.
// A cancel sweeps every slot through the single read port of the entry memory
// and answers nothing. A tick fires its expired timers one by one: each fired
// timer costs one full sweep of the entry memory to find the next minimum, plus
// a final sweep that finds none. Stalls on the response side lengthen a create
// or a tick. No clearing pass after reset.
module expiry_ordered_timer_queue import eotq_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    eotq_req_if.sink   req,
    eotq_rsp_if.source rsp
);

    ctl_cmd_t   cmd;
    dp_status_t st;
    logic       ready;

    eotq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready),
        .st        (st),
        .cmd       (cmd)
    );

    eotq_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_mode      (req.mode),
        .req_delay     (req.delay),
        .req_source    (req.src_tag),
        .req_cancel_id (req.cancel_id),
        .cmd           (cmd),
        .st            (st),
        .rsp           (rsp)
    );

    assign req.ready = ready;

endmodule

FILE: verif/expiry_ordered_timer_queue_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the timer queue against a shadow timer table
module expiry_ordered_timer_queue_tb;
    import eotq_pkg::*;

    localparam int NUM_SLOTS = SLOTS_DEF;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 4 * (NUM_SLOTS + 2);
    localparam int MAX_REPORTS = 40;
    localparam int FILL_IDS = NUM_SLOTS + 10;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [DELAY_W-1:0] delay;
        logic [OWNER_W-1:0] source;
        logic [ID_W-1:0]    cancel_id;
    } timer_req_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ID_W-1:0]    ident;
        logic [OWNER_W-1:0] owner;
        logic [TIME_W-1:0]  expiry;
        logic               last;
    } timer_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    eotq_req_if req_ch ();
    eotq_rsp_if rsp_ch ();

    expiry_ordered_timer_queue #(.SLOTS(NUM_SLOTS)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic               drv_valid = 1'b0;
    logic [MODE_W-1:0]  drv_mode = '0;
    logic [DELAY_W-1:0] drv_delay = '0;
    logic [OWNER_W-1:0] drv_source = '0;
    logic [ID_W-1:0]    drv_cancel_id = '0;
    logic               sink_ready = 1'b0;

    assign req_ch.valid     = drv_valid;
    assign req_ch.mode      = drv_mode;
    assign req_ch.delay     = drv_delay;
    assign req_ch.src_tag   = drv_source;
    assign req_ch.cancel_id = drv_cancel_id;
    assign rsp_ch.ready     = sink_ready;

    timer_req_t request_q[$];
    timer_rsp_t awaited_rsp[$];
    timer_req_t drv_next;
    timer_rsp_t rsp_got;
    timer_rsp_t rsp_want;

    int total_items = 0;
    int accepted_items = 0;
    int fail_count = 0;
    int req_gap = 0;
    int req_calm = 0;
    int rsp_stall = 0;
    int rsp_calm = 0;

    // shadow of the timer table
    logic               tbl_live   [NUM_SLOTS];
    logic [TIME_W-1:0]  tbl_expiry [NUM_SLOTS];
    logic [ID_W-1:0]    tbl_ident  [NUM_SLOTS];
    logic [OWNER_W-1:0] tbl_owner  [NUM_SLOTS];
    logic [TIME_W-1:0]  now_ms = '0;
    logic [ID_W-1:0]    ident_next = ID_FIRST;

    function automatic int idle_len(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(99, 0);
        if (roll < 2)
        begin
            calm = $urandom_range(40, 20);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // updates the shadow table and queues the words this request should produce
    task automatic apply_timer_request(input timer_req_t r);
        int free_slot;
        int best;
        logic [TIME_W:0] sum;
        timer_rsp_t word;
        timer_rsp_t held;
        bit have_held;
        free_slot = -1;
        best = -1;
        have_held = 1'b0;
        word = '0;
        held = '0;
        case (r.mode)
            MODE_CREATE:
            begin
                for (int i = NUM_SLOTS - 1; i >= 0; i--)
                    if (!tbl_live[i])
                        free_slot = i;
                if (free_slot < 0)
                begin
                    word.kind = KIND_REJECTED;
                    word.last = 1'b1;
                    awaited_rsp = {awaited_rsp, word};
                end
                else
                begin
                    sum = {1'b0, now_ms} + r.delay;
                    tbl_live[free_slot]   = 1'b1;
                    tbl_expiry[free_slot] = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
                    tbl_ident[free_slot]  = ident_next;
                    tbl_owner[free_slot]  = r.source;
                    word.kind     = KIND_CREATED;
                    word.ident    = ident_next;
                    word.expiry   = tbl_expiry[free_slot];
                    word.last     = 1'b1;
                    awaited_rsp = {awaited_rsp, word};
                    ident_next = ident_next + 1'b1;
                end
            end
            MODE_CANCEL:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (tbl_live[i] && tbl_ident[i] == r.cancel_id)
                        tbl_live[i] = 1'b0;
            end
            MODE_TICK:
            begin
                if (now_ms != TIME_MAX)
                    now_ms = now_ms + 1'b1;
                do
                begin
                    best = -1;
                    // strict compare keeps the lower slot on a full tie
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (tbl_live[i] && tbl_expiry[i] <= now_ms)
                            if (best < 0 || tbl_expiry[i] < tbl_expiry[best] ||
                                (tbl_expiry[i] == tbl_expiry[best] &&
                                 tbl_ident[i] < tbl_ident[best]))
                                best = i;
                    if (best >= 0)
                    begin
                        if (have_held)
                            awaited_rsp = {awaited_rsp, held};
                        held.kind     = KIND_FIRED;
                        held.ident    = tbl_ident[best];
                        held.owner    = tbl_owner[best];
                        held.expiry   = tbl_expiry[best];
                        held.last     = 1'b0;
                        have_held     = 1'b1;
                        tbl_live[best] = 1'b0;
                    end
                end
                while (best >= 0);
                if (have_held)
                begin
                    held.last = 1'b1;
                    awaited_rsp = {awaited_rsp, held};
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic push_word(input logic [MODE_W-1:0] mode, input logic [DELAY_W-1:0] delay,
                             input logic [OWNER_W-1:0] source,
                             input logic [ID_W-1:0] cancel_id);
        timer_req_t r;
        r.mode      = mode;
        r.delay     = delay;
        r.source    = source;
        r.cancel_id = cancel_id;
        request_q = {request_q, r};
        total_items++;
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5_000_000;
        $display("expiry_ordered_timer_queue_tb NOT OK");
        $finish;
    end

    // request driver: the expectation is formed when a word is first presented,
    // which is acceptance order since a presented word is never withdrawn
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid     <= 1'b0;
            drv_mode      <= '0;
            drv_delay     <= '0;
            drv_source    <= '0;
            drv_cancel_id <= '0;
        end
        else
        begin
            if (drv_valid && req_ch.ready)
                accepted_items <= accepted_items + 1;
            if (!drv_valid || req_ch.ready)
            begin
                if (req_gap > 0 || request_q.size() == 0)
                begin
                    if (req_gap > 0)
                        req_gap--;
                    drv_valid <= 1'b0;
                end
                else
                begin
                    drv_next = request_q.pop_front();
                    apply_timer_request(drv_next);
                    drv_valid     <= 1'b1;
                    drv_mode      <= drv_next.mode;
                    drv_delay     <= drv_next.delay;
                    drv_source    <= drv_next.source;
                    drv_cancel_id <= drv_next.cancel_id;
                    req_gap = idle_len(req_calm);
                end
            end
        end
    end

    // response monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && sink_ready)
            begin
                rsp_got.kind   = rsp_ch.kind;
                rsp_got.ident  = rsp_ch.ident;
                rsp_got.owner  = rsp_ch.owner;
                rsp_got.expiry = rsp_ch.expiry;
                rsp_got.last   = rsp_ch.last;
                if (awaited_rsp.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: expected no word, got kind %0d id %0d owner %0h expiry %0d last %0b",
                                 $time, rsp_got.kind, rsp_got.ident, rsp_got.owner,
                                 rsp_got.expiry, rsp_got.last);
                    fail_count++;
                end
                else
                begin
                    rsp_want = awaited_rsp.pop_front();
                    if (rsp_got !== rsp_want)
                    begin
                        if (fail_count < MAX_REPORTS)
                            $display("%0t: expected kind %0d id %0d owner %0h expiry %0d last %0b, got kind %0d id %0d owner %0h expiry %0d last %0b",
                                     $time, rsp_want.kind, rsp_want.ident, rsp_want.owner,
                                     rsp_want.expiry, rsp_want.last, rsp_got.kind,
                                     rsp_got.ident, rsp_got.owner, rsp_got.expiry,
                                     rsp_got.last);
                        fail_count++;
                    end
                end
                rsp_stall = idle_len(rsp_calm);
            end
            if (rsp_stall > 0)
            begin
                rsp_stall--;
                sink_ready <= 1'b0;
            end
            else
            begin
                sink_ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned id_gen;
        int unsigned base;
        int unsigned lo;
        int unsigned order [FILL_IDS];
        int unsigned tmp;
        int roll;
        int j;
        logic [DELAY_W-1:0] dly;
        logic [ID_W-1:0] cid;

        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            tbl_live[i]   = 1'b0;
            tbl_expiry[i] = '0;
            tbl_ident[i]  = '0;
            tbl_owner[i]  = '0;
        end

        // directed: zero delay, ties on expiry, long delay, unknown cancels, unused mode
        push_word(MODE_CREATE, 32'd0, 32'hFFFF_FFFF, 32'd0);
        push_word(MODE_TICK, 32'd0, 32'd0, 32'd0);
        push_word(MODE_CREATE, 32'd2, 32'd0, 32'd0);
        push_word(MODE_CREATE, 32'd1, 32'hA5A5_A5A5, 32'd0);
        push_word(MODE_CREATE, 32'd1, 32'h5A5A_5A5A, 32'd0);
        push_word(MODE_CREATE, 32'hFFFF_FFFF, 32'h1234_5678, 32'd0);
        push_word(MODE_TICK, 32'd0, 32'd0, 32'd0);
        push_word(MODE_CANCEL, 32'd0, 32'd0, 32'd5);
        push_word(MODE_CANCEL, 32'd0, 32'd0, 32'hFFFF_FFFF);
        push_word(MODE_CANCEL, 32'd0, 32'd0, 32'd0);
        push_word(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_word(MODE_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_word(MODE_TICK, 32'd0, 32'd0, 32'd0);
        push_word(MODE_CREATE, 32'd3, 32'd1, 32'd0);
        push_word(MODE_CREATE, 32'd0, 32'd2, 32'hFFFF_FFFF);
        push_word(MODE_CANCEL, 32'd0, 32'd0, 32'd6);
        push_word(MODE_TICK, 32'd0, 32'd0, 32'd0);
        push_word(MODE_TICK, 32'd0, 32'd0, 32'd0);
        push_word(MODE_CREATE, 32'd1, 32'd3, 32'd0);
        push_word(MODE_CREATE, 32'd1, 32'd4, 32'd0);
        push_word(MODE_TICK, 32'd0, 32'd0, 32'd0);
        push_word(MODE_CANCEL, 32'd0, 32'd0, 32'd9);
        id_gen = 10;

        // a full table of near timers, one rejected create, one tick fires all of them
        for (int i = 0; i < NUM_SLOTS; i++)
            push_word(MODE_CREATE, $urandom_range(1, 0), $urandom, $urandom);
        push_word(MODE_CREATE, $urandom, $urandom, $urandom);
        push_word(MODE_TICK, $urandom, $urandom, $urandom);
        id_gen += NUM_SLOTS;

        // fill with far timers, reject, free a few, refill, then cancel everything
        base = id_gen;
        for (int i = 0; i < NUM_SLOTS; i++)
            push_word(MODE_CREATE, $urandom_range(32'hFFFF_FFFF, 32'd100000), $urandom,
                      $urandom);
        push_word(MODE_CREATE, $urandom, $urandom, $urandom);
        push_word(MODE_CREATE, $urandom, $urandom, $urandom);
        for (int i = 0; i < 10; i++)
        begin
            push_word(MODE_CANCEL, $urandom, $urandom, base + 6 * i + $urandom_range(5, 0));
            if ($urandom_range(3, 0) == 0)
                push_word(MODE_TICK, $urandom, $urandom, $urandom);
        end
        for (int i = 0; i < 10; i++)
            push_word(MODE_CREATE, $urandom_range(32'hFFFF_FFFF, 32'd100000), $urandom,
                      $urandom);
        push_word(MODE_CREATE, $urandom, $urandom, $urandom);
        for (int i = 0; i < FILL_IDS; i++)
            order[i] = base + i;
        for (int i = FILL_IDS - 1; i > 0; i--)
        begin
            j = $urandom_range(i, 0);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < FILL_IDS; i++)
        begin
            push_word(MODE_CANCEL, $urandom, $urandom, order[i]);
            if ($urandom_range(7, 0) == 0)
                push_word(MODE_TICK, $urandom, $urandom, $urandom);
        end
        id_gen = base + FILL_IDS;

        // mixed traffic, mostly short delays so ticks keep firing
        for (int n = 0; n < 60; n++)
        begin
            roll = $urandom_range(99, 0);
            if (roll < 40)
            begin
                tmp = $urandom_range(99, 0);
                if (tmp < 55)
                    dly = $urandom_range(6, 0);
                else if (tmp < 85)
                    dly = $urandom_range(40, 0);
                else
                    dly = $urandom;
                push_word(MODE_CREATE, dly, $urandom, $urandom);
                id_gen++;
            end
            else if (roll < 78)
            begin
                push_word(MODE_TICK, $urandom, $urandom, $urandom);
            end
            else if (roll < 95)
            begin
                lo = (id_gen > 20) ? id_gen - 20 : 0;
                if ($urandom_range(3, 0) == 0)
                    cid = $urandom;
                else
                    cid = $urandom_range(id_gen, lo);
                push_word(MODE_CANCEL, $urandom, $urandom, cid);
            end
            else
            begin
                push_word(MODE_UNUSED, $urandom, $urandom, $urandom);
            end
        end

        while (accepted_items != total_items)
            @(posedge clk);
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        // let a trailing cancel or empty tick finish its sweep
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("expiry_ordered_timer_queue_tb OK");
        else
            $display("expiry_ordered_timer_queue_tb NOT OK");
        $finish;
    end

endmodule
